// ===== rtl/ttd_pkg.sv =====
// Shared types, constants and codes for the tick task dispatcher.
`default_nettype none

package ttd_pkg;

    // Table geometry.
    localparam int SLOTS = 8;
    localparam int CNT_W = $clog2(SLOTS);

    // Field widths.
    localparam int OP_W    = 3;
    localparam int ID_W    = 16;
    localparam int CVAL_W  = 24;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 8;
    localparam int STAT_W  = 2;

    // Slot pass position of the last slot.
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS - 1);

    // Opcodes.
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_REG   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL   = 3'd2;
    localparam logic [OP_W-1:0] OP_DELAY = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    // Skip phase codes of a slot.
    localparam logic [1:0] SKIP_NONE = 2'd0;
    localparam logic [1:0] SKIP_WAIT = 2'd1;
    localparam logic [1:0] SKIP_DONE = 2'd2;

    // Constants.
    localparam logic [CVAL_W-1:0]  SKIP_THRESHOLD = 24'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'hFF;
    localparam logic [CVAL_W-1:0]  RELOAD_RESET   = 24'd167999;

    // One task slot.
    typedef struct packed {
        logic            used;
        logic [1:0]      skip;
        logic [ID_W-1:0] task_id;
    } slot_t;

    // Per-item control handed to the head unit.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] task_id;
        logic            skip_init;
        logic            done;
    } head_ctl_t;

    // What the head unit decided for the slot passing through it.
    typedef struct packed {
        slot_t slot;
        logic  fire;
        logic  claim;
        logic  added;
        logic  removed;
    } head_res_t;

endpackage

`default_nettype wire

// ===== rtl/ttd_cell.sv =====
// One slot cell of the rotating slot chain.
`default_nettype none

module ttd_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           shift,
    input  wire ttd_pkg::slot_t d,
    output ttd_pkg::slot_t      q
);

    ttd_pkg::slot_t slot_reg;

    // The cell takes its neighbor's slot whenever the chain advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (shift)
        begin
            slot_reg <= d;
        end
    end

    assign q = slot_reg;

endmodule

`default_nettype wire

// ===== rtl/ttd_head.sv =====
// Head unit: updates the slot that leaves the end of the chain.
`default_nettype none

module ttd_head (
    input  wire ttd_pkg::slot_t     slot_in,
    input  wire ttd_pkg::head_ctl_t ctl,
    output ttd_pkg::head_res_t      res
);

    always_comb
    begin
        res.slot    = slot_in;
        res.fire    = 1'b0;
        res.claim   = 1'b0;
        res.added   = 1'b0;
        res.removed = 1'b0;
        case (ctl.op)
            ttd_pkg::OP_TICK:
            begin
                // A waiting slot moves on one phase; any other used slot runs.
                if (slot_in.used)
                begin
                    if (slot_in.skip == ttd_pkg::SKIP_WAIT)
                    begin
                        res.slot.skip = ttd_pkg::SKIP_DONE;
                    end
                    else
                    begin
                        res.slot.skip = ttd_pkg::SKIP_NONE;
                        res.fire      = 1'b1;
                    end
                end
            end
            ttd_pkg::OP_REG:
            begin
                // The first slot that holds the identity or is free ends the search.
                if (!ctl.done)
                begin
                    if (slot_in.used && slot_in.task_id == ctl.task_id)
                    begin
                        res.claim = 1'b1;
                    end
                    else if (!slot_in.used)
                    begin
                        res.slot.used    = 1'b1;
                        res.slot.skip    = ctl.skip_init ? ttd_pkg::SKIP_WAIT
                                                         : ttd_pkg::SKIP_NONE;
                        res.slot.task_id = ctl.task_id;
                        res.claim        = 1'b1;
                        res.added        = 1'b1;
                    end
                end
            end
            ttd_pkg::OP_DEL:
            begin
                // The first used slot with the identity is emptied.
                if (!ctl.done && slot_in.used && slot_in.task_id == ctl.task_id)
                begin
                    res.slot    = '0;
                    res.claim   = 1'b1;
                    res.removed = 1'b1;
                end
            end
            ttd_pkg::OP_CLEAR:
            begin
                res.slot = '0;
            end
            default:
            begin
                res.slot = slot_in;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tick_task_dispatcher_top.sv =====
// Top level of the tick task dispatcher: slot chain, head unit and control.
//
// Use: an item (opcode, task_id, counter_value, delay_ticks) is transferred on
// the input channel when in_valid is high and in_stall is low. Results leave on
// the output channel when out_valid is high and out_stall is low; each carries
// status, fire information, the last flag and the counters after the item.
// The reload value is written on the cfg channel, which is always ready; write
// it only while the block is idle.
// Flow: the block takes an item, the slot chain rotates once past the head
// unit, one slot per cycle while the chain does not hold, and the final result
// is handed over. A tick gives one result per firing slot, in slot order, and
// the chain holds its place whenever a result is due while the output register
// is still occupied, so a stalling receiver lengthens the item. The next item
// is taken once the final result sits in the output register.
// Reset empties all slots, zeroes the counters, drops the output register and
// sets the reload value to 167999. No clearing pass follows reset.
`default_nettype none

module tick_task_dispatcher_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [ttd_pkg::OP_W-1:0]       opcode,
    input  wire logic [ttd_pkg::ID_W-1:0]       task_id,
    input  wire logic [ttd_pkg::CVAL_W-1:0]     counter_value,
    input  wire logic [ttd_pkg::WORD_W-1:0]     delay_ticks,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [ttd_pkg::STAT_W-1:0]          status,
    output logic                                fire_valid,
    output logic [ttd_pkg::ID_W-1:0]            fired_task,
    output logic                                last,
    output logic [ttd_pkg::WORD_W-1:0]          tick_count,
    output logic [ttd_pkg::WORD_W-1:0]          overflow_count,
    output logic [ttd_pkg::WORD_W-1:0]          delay_remaining,
    output logic [ttd_pkg::COUNT_W-1:0]         task_count,
    // configuration channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ttd_pkg::CVAL_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                         state_reg;
    logic [ttd_pkg::CNT_W-1:0]      cnt_reg;
    logic [ttd_pkg::OP_W-1:0]       op_reg;
    logic [ttd_pkg::ID_W-1:0]       id_reg;
    logic                           skip_init_reg;
    logic                           done_reg;
    logic                           zero_id_reg;
    logic                           pend_valid_reg;
    logic [ttd_pkg::ID_W-1:0]       pend_task_reg;
    logic [ttd_pkg::CVAL_W-1:0]     reload_reg;
    logic [ttd_pkg::WORD_W-1:0]     ticks_reg;
    logic [ttd_pkg::WORD_W-1:0]     wraps_reg;
    logic [ttd_pkg::WORD_W-1:0]     delay_reg;
    logic [ttd_pkg::COUNT_W-1:0]    registered_reg;

    logic                           out_valid_reg;
    logic [ttd_pkg::STAT_W-1:0]     out_status_reg;
    logic                           out_fire_reg;
    logic [ttd_pkg::ID_W-1:0]       out_task_reg;
    logic                           out_last_reg;
    logic [ttd_pkg::WORD_W-1:0]     out_ticks_reg;
    logic [ttd_pkg::WORD_W-1:0]     out_wraps_reg;
    logic [ttd_pkg::WORD_W-1:0]     out_delay_reg;
    logic [ttd_pkg::COUNT_W-1:0]    out_count_reg;

    ttd_pkg::slot_t                 cell_q [ttd_pkg::SLOTS];
    ttd_pkg::head_ctl_t             head_ctl;
    ttd_pkg::head_res_t             head_res;
    logic                           out_free;
    logic                           advance;
    logic                           shift;
    logic                           out_load;
    logic [ttd_pkg::CVAL_W:0]       half_reload;
    logic                           extra_tick;
    logic [ttd_pkg::STAT_W-1:0]     final_status;

    // Slot chain: the head unit feeds cell 0, the last cell feeds the head.
    genvar gi;
    generate
        for (gi = 0; gi < ttd_pkg::SLOTS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                ttd_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (head_res.slot),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_rest
                ttd_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (cell_q[gi-1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    // Head unit on the slot leaving the chain.
    assign head_ctl.op        = op_reg;
    assign head_ctl.task_id   = id_reg;
    assign head_ctl.skip_init = skip_init_reg;
    assign head_ctl.done      = done_reg;

    ttd_head u_head (
        .slot_in (cell_q[ttd_pkg::SLOTS-1]),
        .ctl     (head_ctl),
        .res     (head_res)
    );

    // The chain waits when a fired task must push out a buffered one and the
    // output register cannot take it.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = !(head_res.fire && pend_valid_reg && !out_free);
    assign shift    = (state_reg == S_SCAN) && advance;

    // A result enters the output register when a fired task pushes out the
    // buffered one, or as the final result of the item.
    assign out_load = ((state_reg == S_SCAN) && advance && head_res.fire && pend_valid_reg)
                   || ((state_reg == S_FINISH) && out_free);

    // Extra delay tick when the timer sample lies in the lower half period.
    assign half_reload = ({1'b0, reload_reg} + 25'd1) >> 1;
    assign extra_tick  = {1'b0, counter_value} < half_reload;

    // Status of the single result of a non-tick item.
    always_comb
    begin
        if ((op_reg == ttd_pkg::OP_REG) || (op_reg == ttd_pkg::OP_DEL))
        begin
            if (zero_id_reg)
            begin
                final_status = ttd_pkg::ST_ZERO;
            end
            else if (done_reg)
            begin
                final_status = ttd_pkg::ST_OK;
            end
            else
            begin
                final_status = ttd_pkg::ST_MISS;
            end
        end
        else
        begin
            final_status = ttd_pkg::ST_OK;
        end
    end

    // Control, counters and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            reload_reg     <= ttd_pkg::RELOAD_RESET;
            ticks_reg      <= '0;
            wraps_reg      <= '0;
            delay_reg      <= '0;
            registered_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                reload_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= opcode;
                        id_reg         <= task_id;
                        skip_init_reg  <= counter_value > ttd_pkg::SKIP_THRESHOLD;
                        zero_id_reg    <= task_id == '0;
                        done_reg       <= task_id == '0;
                        pend_valid_reg <= 1'b0;
                        cnt_reg        <= '0;
                        state_reg      <= S_SCAN;
                        case (opcode)
                            ttd_pkg::OP_TICK:
                            begin
                                ticks_reg <= ticks_reg + 32'd1;
                                if (ticks_reg == '1)
                                begin
                                    wraps_reg <= wraps_reg + 32'd1;
                                end
                                if (delay_reg != '0)
                                begin
                                    delay_reg <= delay_reg - 32'd1;
                                end
                            end
                            ttd_pkg::OP_DELAY:
                            begin
                                delay_reg <= delay_ticks + {31'd0, extra_tick};
                            end
                            ttd_pkg::OP_CLEAR:
                            begin
                                ticks_reg <= '0;
                                wraps_reg <= '0;
                                delay_reg <= '0;
                            end
                            default:
                            begin
                                ticks_reg <= ticks_reg;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (advance)
                    begin
                        done_reg <= done_reg | head_res.claim;
                        if (head_res.added && registered_reg != ttd_pkg::COUNT_MAX)
                        begin
                            registered_reg <= registered_reg + 8'd1;
                        end
                        if (head_res.removed && registered_reg != '0)
                        begin
                            registered_reg <= registered_reg - 8'd1;
                        end
                        if (head_res.fire)
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_task_reg  <= cell_q[ttd_pkg::SLOTS-1].task_id;
                            // The buffered task is known not to be the last one.
                            if (pend_valid_reg)
                            begin
                                out_status_reg <= ttd_pkg::ST_OK;
                                out_fire_reg   <= 1'b1;
                                out_task_reg   <= pend_task_reg;
                                out_last_reg   <= 1'b0;
                                out_ticks_reg  <= ticks_reg;
                                out_wraps_reg  <= wraps_reg;
                                out_delay_reg  <= delay_reg;
                                out_count_reg  <= registered_reg;
                            end
                        end
                        if (cnt_reg == ttd_pkg::CNT_LAST)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_FINISH:
                begin
                    // Final result: the buffered task, an empty tick, or the status.
                    if (out_free)
                    begin
                        out_status_reg <= final_status;
                        out_fire_reg   <= pend_valid_reg;
                        out_task_reg   <= pend_valid_reg ? pend_task_reg : '0;
                        out_last_reg   <= 1'b1;
                        out_ticks_reg  <= ticks_reg;
                        out_wraps_reg  <= wraps_reg;
                        out_delay_reg  <= delay_reg;
                        out_count_reg  <= registered_reg;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign fire_valid      = out_fire_reg;
    assign fired_task      = out_task_reg;
    assign last            = out_last_reg;
    assign tick_count      = out_ticks_reg;
    assign overflow_count  = out_wraps_reg;
    assign delay_remaining = out_delay_reg;
    assign task_count      = out_count_reg;

    // The pass counter never runs past the last slot.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ttd_pkg::CNT_LAST)
        else $error("slot pass counter out of range");

    // Only a tick buffers a fired task.
    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (op_reg == ttd_pkg::OP_TICK))
        else $error("fired task buffered outside a tick");

    // The task count moves only while the chain rotates.
    a_count_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCAN) |=> $stable(registered_reg))
        else $error("task count changed outside a slot pass");

endmodule

`default_nettype wire

// ===== test/dispatch_checker.sv =====
// Checker for the tick task dispatcher: watches all channels, predicts and compares results.
module dispatch_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_stall,
    input  wire logic [ttd_pkg::OP_W-1:0]     opcode,
    input  wire logic [ttd_pkg::ID_W-1:0]     task_id,
    input  wire logic [ttd_pkg::CVAL_W-1:0]   counter_value,
    input  wire logic [ttd_pkg::WORD_W-1:0]   delay_ticks,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire logic [ttd_pkg::STAT_W-1:0]   status,
    input  wire logic                         fire_valid,
    input  wire logic [ttd_pkg::ID_W-1:0]     fired_task,
    input  wire logic                         last,
    input  wire logic [ttd_pkg::WORD_W-1:0]   tick_count,
    input  wire logic [ttd_pkg::WORD_W-1:0]   overflow_count,
    input  wire logic [ttd_pkg::WORD_W-1:0]   delay_remaining,
    input  wire logic [ttd_pkg::COUNT_W-1:0]  task_count,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_ready,
    input  wire logic [ttd_pkg::CVAL_W-1:0]   cfg_data,
    output int unsigned                       in_flight,
    output int unsigned                       fail_count,
    output int unsigned                       results_seen,
    output int unsigned                       fires_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result transfer as the block should present it.
    typedef struct packed {
        logic [ttd_pkg::STAT_W-1:0]  status;
        logic                        fire;
        logic [ttd_pkg::ID_W-1:0]    fired_id;
        logic                        is_last;
        logic [ttd_pkg::WORD_W-1:0]  ticks;
        logic [ttd_pkg::WORD_W-1:0]  wraps;
        logic [ttd_pkg::WORD_W-1:0]  delay;
        logic [ttd_pkg::COUNT_W-1:0] count;
    } dispatch_result_t;

    // Predicted dispatcher state.
    logic [ttd_pkg::ID_W-1:0]    slot_id   [ttd_pkg::SLOTS];
    logic                        slot_busy [ttd_pkg::SLOTS];
    logic [1:0]                  slot_wait [ttd_pkg::SLOTS];
    logic [ttd_pkg::WORD_W-1:0]  tick_ctr;
    logic [ttd_pkg::WORD_W-1:0]  wrap_ctr;
    logic [ttd_pkg::WORD_W-1:0]  delay_ctr;
    logic [ttd_pkg::COUNT_W-1:0] reg_ctr;
    logic [ttd_pkg::CVAL_W-1:0]  reload_copy;

    dispatch_result_t expected_results [$];
    dispatch_result_t oldest;
    int unsigned      mismatches = 0;

    // Empty the table and zero the tick, wrap and delay counters.
    function automatic void clear_slots();
        for (int i = 0; i < ttd_pkg::SLOTS; i++)
        begin
            slot_id[i]   = '0;
            slot_busy[i] = 1'b0;
            slot_wait[i] = ttd_pkg::SKIP_NONE;
        end
        tick_ctr  = '0;
        wrap_ctr  = '0;
        delay_ctr = '0;
    endfunction

    // Queue one expected result carrying the counters as they stand now.
    function automatic void push_result(logic [ttd_pkg::STAT_W-1:0] st, logic fire,
                                        logic [ttd_pkg::ID_W-1:0] id, logic fin);
        dispatch_result_t r;
        r.status   = st;
        r.fire     = fire;
        r.fired_id = id;
        r.is_last  = fin;
        r.ticks    = tick_ctr;
        r.wraps    = wrap_ctr;
        r.delay    = delay_ctr;
        r.count    = reg_ctr;
        expected_results.push_back(r);
    endfunction

    // Advance the predicted state by one accepted item and queue its results.
    function automatic void predict_dispatch(logic [ttd_pkg::OP_W-1:0] op,
                                             logic [ttd_pkg::ID_W-1:0] id,
                                             logic [ttd_pkg::CVAL_W-1:0] cval,
                                             logic [ttd_pkg::WORD_W-1:0] dreq);
        logic [ttd_pkg::STAT_W-1:0] st;
        logic [ttd_pkg::ID_W-1:0]   fired [$];
        logic [ttd_pkg::WORD_W-1:0] half_reload;
        logic                       found;
        st    = ttd_pkg::ST_OK;
        found = 1'b0;
        case (op)
            ttd_pkg::OP_TICK:
            begin
                tick_ctr = tick_ctr + 1'b1;
                if (tick_ctr == '0)
                    wrap_ctr = wrap_ctr + 1'b1;
                if (delay_ctr != '0)
                    delay_ctr = delay_ctr - 1'b1;
                // A slot in its first skip phase waits one tick; all others fire.
                for (int i = 0; i < ttd_pkg::SLOTS; i++)
                begin
                    if (slot_busy[i])
                    begin
                        if (slot_wait[i] == ttd_pkg::SKIP_WAIT)
                            slot_wait[i] = ttd_pkg::SKIP_DONE;
                        else
                        begin
                            slot_wait[i] = ttd_pkg::SKIP_NONE;
                            fired.push_back(slot_id[i]);
                        end
                    end
                end
                if (fired.size() == 0)
                    push_result(ttd_pkg::ST_OK, 1'b0, '0, 1'b1);
                for (int i = 0; i < fired.size(); i++)
                    push_result(ttd_pkg::ST_OK, 1'b1, fired[i], i == fired.size() - 1);
            end
            ttd_pkg::OP_REG:
            begin
                if (id == '0)
                    st = ttd_pkg::ST_ZERO;
                else
                begin
                    // The scan stops at a matching used slot or at the first free one.
                    for (int i = 0; i < ttd_pkg::SLOTS; i++)
                    begin
                        if (!found && slot_busy[i] && slot_id[i] == id)
                            found = 1'b1;
                        else if (!found && !slot_busy[i])
                        begin
                            found        = 1'b1;
                            slot_wait[i] = (cval > ttd_pkg::SKIP_THRESHOLD)
                                           ? ttd_pkg::SKIP_WAIT : ttd_pkg::SKIP_NONE;
                            slot_id[i]   = id;
                            slot_busy[i] = 1'b1;
                            if (reg_ctr < ttd_pkg::COUNT_MAX)
                                reg_ctr = reg_ctr + 1'b1;
                        end
                    end
                    if (!found)
                        st = ttd_pkg::ST_MISS;
                end
            end
            ttd_pkg::OP_DEL:
            begin
                if (id == '0)
                    st = ttd_pkg::ST_ZERO;
                else
                begin
                    for (int i = 0; i < ttd_pkg::SLOTS; i++)
                    begin
                        if (!found && slot_busy[i] && slot_id[i] == id)
                        begin
                            found        = 1'b1;
                            slot_id[i]   = '0;
                            slot_busy[i] = 1'b0;
                            slot_wait[i] = ttd_pkg::SKIP_NONE;
                            if (reg_ctr > '0)
                                reg_ctr = reg_ctr - 1'b1;
                        end
                    end
                    if (!found)
                        st = ttd_pkg::ST_MISS;
                end
            end
            ttd_pkg::OP_DELAY:
            begin
                // A sample in the lower half of the reload period costs one extra tick.
                half_reload = ({8'b0, reload_copy} + 32'd1) >> 1;
                if ({8'b0, cval} < half_reload)
                    dreq = dreq + 1'b1;
                delay_ctr = dreq;
            end
            ttd_pkg::OP_CLEAR:
                clear_slots();
            default:
                ;
        endcase
        if (op != ttd_pkg::OP_TICK)
            push_result(st, 1'b0, '0, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [ttd_pkg::WORD_W-1:0] want,
                                        logic [ttd_pkg::WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Result transfers are compared first, then an accepted item is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_slots();
            reg_ctr     = '0;
            reload_copy = ttd_pkg::RELOAD_RESET;
            expected_results.delete();
            in_flight <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (fire_valid === 1'b1)
                    fires_seen <= fires_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no expectation: fired_task %0h", fired_task);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("status", 32'(oldest.status), 32'(status));
                    check_field("fire_valid", 32'(oldest.fire), 32'(fire_valid));
                    check_field("fired_task", 32'(oldest.fired_id), 32'(fired_task));
                    check_field("last", 32'(oldest.is_last), 32'(last));
                    check_field("tick_count", oldest.ticks, tick_count);
                    check_field("overflow_count", oldest.wraps, overflow_count);
                    check_field("delay_remaining", oldest.delay, delay_remaining);
                    check_field("task_count", 32'(oldest.count), 32'(task_count));
                end
            end
            if (in_valid && !in_stall)
                predict_dispatch(opcode, task_id, counter_value, delay_ticks);
            if (cfg_valid && cfg_ready)
                reload_copy = cfg_data;
            in_flight  <= expected_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the tick task dispatcher testbench: clock, reset, stimulus and verdict.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         in_valid      = 1'b0;
    logic                         in_stall;
    logic [ttd_pkg::OP_W-1:0]     opcode        = '0;
    logic [ttd_pkg::ID_W-1:0]     task_id       = '0;
    logic [ttd_pkg::CVAL_W-1:0]   counter_value = '0;
    logic [ttd_pkg::WORD_W-1:0]   delay_ticks   = '0;
    logic                         out_valid;
    logic                         out_stall     = 1'b0;
    logic [ttd_pkg::STAT_W-1:0]   status;
    logic                         fire_valid;
    logic [ttd_pkg::ID_W-1:0]     fired_task;
    logic                         last;
    logic [ttd_pkg::WORD_W-1:0]   tick_count;
    logic [ttd_pkg::WORD_W-1:0]   overflow_count;
    logic [ttd_pkg::WORD_W-1:0]   delay_remaining;
    logic [ttd_pkg::COUNT_W-1:0]  task_count;
    logic                         cfg_valid     = 1'b0;
    logic                         cfg_ready;
    logic [ttd_pkg::CVAL_W-1:0]   cfg_data      = '0;

    int unsigned in_flight;
    int unsigned fail_count;
    int unsigned results_seen;
    int unsigned fires_seen;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned items_sent    = 0;
    int unsigned useful_items  = 0;
    int unsigned reload_writes = 0;
    logic [ttd_pkg::CVAL_W-1:0] reload_now = ttd_pkg::RELOAD_RESET;
    logic [ttd_pkg::ID_W-1:0]   id_pool [10];

    always #1 clk = ~clk;

    tick_task_dispatcher_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .task_id         (task_id),
        .counter_value   (counter_value),
        .delay_ticks     (delay_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .fire_valid      (fire_valid),
        .fired_task      (fired_task),
        .last            (last),
        .tick_count      (tick_count),
        .overflow_count  (overflow_count),
        .delay_remaining (delay_remaining),
        .task_count      (task_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    dispatch_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .task_id         (task_id),
        .counter_value   (counter_value),
        .delay_ticks     (delay_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .fire_valid      (fire_valid),
        .fired_task      (fired_task),
        .last            (last),
        .tick_count      (tick_count),
        .overflow_count  (overflow_count),
        .delay_remaining (delay_remaining),
        .task_count      (task_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_flight       (in_flight),
        .fail_count      (fail_count),
        .results_seen    (results_seen),
        .fires_seen      (fires_seen)
    );

    // The receiver stalls at random in the share set by the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Present one item, idling first at random, and hold it until its transfer.
    task automatic send_item(input logic [ttd_pkg::OP_W-1:0] op,
                             input logic [ttd_pkg::ID_W-1:0] id,
                             input logic [ttd_pkg::CVAL_W-1:0] cval,
                             input logic [ttd_pkg::WORD_W-1:0] dreq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        task_id       <= id;
        counter_value <= cval;
        delay_ticks   <= dreq;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (op <= ttd_pkg::OP_CLEAR)
            useful_items++;
    endtask

    // Stop sending and let every expected result arrive, then let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reload(input logic [ttd_pkg::CVAL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        reload_now  = value;
        reload_writes++;
    endtask

    // Mostly identities from a small pool, so that duplicates and deletes meet.
    function automatic logic [ttd_pkg::ID_W-1:0] pick_id();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return id_pool[$urandom_range(9)];
        else if (roll < 90)
            return '0;
        return 16'($urandom);
    endfunction

    // Timer samples around the skip threshold, the delay threshold, or anywhere.
    function automatic logic [ttd_pkg::CVAL_W-1:0] pick_cval();
        int unsigned roll;
        int          near;
        roll = $urandom_range(99);
        if (roll < 40)
            return 24'($urandom);
        else if (roll < 60)
            return 24'($urandom_range(105, 95));
        else if (roll < 80)
            return 24'($urandom_range(100));
        near = ((int'(reload_now) + 1) >>> 1) + int'($urandom_range(4)) - 2;
        if (near < 0)
            near = 0;
        if (near > 24'hFFFFFF)
            near = 24'hFFFFFF;
        return near[ttd_pkg::CVAL_W-1:0];
    endfunction

    function automatic logic [ttd_pkg::WORD_W-1:0] pick_delay();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(6);
            2: return 32'hFFFF_FFFF;
            default: return '0;
        endcase
    endfunction

    // One short, mostly well-formed sequence of operations with random content.
    task automatic run_sequence();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35)
            repeat ($urandom_range(9, 2))
                send_item(ttd_pkg::OP_REG, pick_id(), pick_cval(), $urandom);
        else if (roll < 60)
            repeat ($urandom_range(4, 1))
                send_item(ttd_pkg::OP_TICK, 16'($urandom), 24'($urandom), $urandom);
        else if (roll < 72)
            repeat ($urandom_range(3, 1))
                send_item(ttd_pkg::OP_DEL, pick_id(), 24'($urandom), $urandom);
        else if (roll < 82)
        begin
            send_item(ttd_pkg::OP_DELAY, 16'($urandom), pick_cval(), pick_delay());
            repeat ($urandom_range(3, 1))
                send_item(ttd_pkg::OP_TICK, 16'($urandom), 24'($urandom), $urandom);
        end
        else if (roll < 90)
            send_item(ttd_pkg::OP_CLEAR, 16'($urandom), 24'($urandom), $urandom);
        else
            send_item(3'($urandom_range(7)), 16'($urandom), 24'($urandom), $urandom);
    endtask

    // Global watchdog.
    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        id_pool[0] = 16'hFFFF;
        id_pool[1] = 16'h0001;
        for (int i = 2; i < 10; i++)
            id_pool[i] = 16'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset reload value.
        send_item(ttd_pkg::OP_TICK, '0, '0, '0);
        send_item(ttd_pkg::OP_REG, '0, 24'd5, '0);
        send_item(ttd_pkg::OP_DEL, '0, '0, '0);
        send_item(ttd_pkg::OP_REG, 16'hFFFF, 24'd0, '0);
        send_item(ttd_pkg::OP_REG, 16'h0001, 24'd101, '0);
        send_item(ttd_pkg::OP_REG, 16'h0005, 24'd100, '0);
        send_item(ttd_pkg::OP_REG, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
        send_item(ttd_pkg::OP_TICK, '0, '0, '0);
        send_item(ttd_pkg::OP_TICK, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
        send_item(ttd_pkg::OP_DEL, 16'hFFFF, '0, '0);
        // Identity held only above a free slot is taken a second time.
        send_item(ttd_pkg::OP_REG, 16'h0001, 24'd0, '0);
        send_item(ttd_pkg::OP_DEL, 16'h1234, '0, '0);
        for (int i = 0; i < 5; i++)
            send_item(ttd_pkg::OP_REG, 16'(16'h0010 + i), 24'hFFFFFF, '0);
        send_item(ttd_pkg::OP_REG, 16'hABCD, 24'd0, '0);
        send_item(ttd_pkg::OP_TICK, '0, '0, '0);
        send_item(ttd_pkg::OP_TICK, '0, '0, '0);
        // Extra delay tick wrapping, and both sides of the half-reload boundary.
        send_item(ttd_pkg::OP_DELAY, '0, 24'd0, 32'hFFFF_FFFF);
        send_item(ttd_pkg::OP_DELAY, '0, 24'd83999, 32'd3);
        send_item(ttd_pkg::OP_DELAY, '0, 24'd84000, 32'd2);
        send_item(ttd_pkg::OP_TICK, '0, '0, '0);
        send_item(3'd5, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
        send_item(3'd6, '0, '0, '0);
        send_item(3'd7, 16'h5A5A, 24'hA5A5A5, 32'h5A5A_A5A5);
        send_item(ttd_pkg::OP_CLEAR, '0, '0, '0);
        send_item(ttd_pkg::OP_TICK, '0, '0, '0);

        // Random phases, each under its own reload value and idling mix.
        for (int p = 0; p < 4; p++)
        begin
            int unsigned phase_start;
            wait_idle();
            case (p)
                0:
                begin
                    write_reload('0);
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    write_reload(24'hFFFFFF);
                    send_idle_pct = 67;
                    stall_pct     = 0;
                end
                2:
                begin
                    write_reload(24'd1);
                    send_idle_pct = 0;
                    stall_pct     = 67;
                end
                default:
                begin
                    write_reload(24'($urandom));
                    send_idle_pct = 14;
                    stall_pct     = 14;
                end
            endcase
            phase_start = useful_items;
            while (useful_items - phase_start < 55)
                run_sequence();
        end

        wait_idle();
        $display("testbench: %0d items sent under %0d reload settings besides the reset one",
                 items_sent, reload_writes);
        $display("testbench: %0d results checked, %0d of them fired tasks",
                 results_seen, fires_seen);
        if (fail_count == 0 && in_flight == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ttd_pkg.sv
rtl/ttd_cell.sv
rtl/ttd_head.sv
rtl/tick_task_dispatcher_top.sv
test/dispatch_checker.sv
test/testbench.sv
